### sv/rppt_pkg.sv
// shared types, constants and coefficient table for the rgb pixel point transform
`timescale 1ns / 1ps
package rppt_pkg;

	localparam int unsigned SUM_BITS   = 18;
	localparam int unsigned OUT_BITS   = 17;
	localparam int unsigned QUOT_BITS  = 34;
	localparam int unsigned DOT_BITS   = 27;
	localparam int unsigned PROD_BITS  = 49;
	localparam int unsigned RECIP_SHIFT = 31;
	localparam logic [24:0] RECIP_MULT = 25'd17179869;
	localparam logic [6:0]  RECIP_DIV  = 7'd125;

	localparam logic [2:0] MODE_BITMAP    = 3'd0;
	localparam logic [2:0] MODE_GRAYSCALE = 3'd1;
	localparam logic [2:0] MODE_ISOLATE   = 3'd2;
	localparam logic [2:0] MODE_REMOVE    = 3'd3;
	localparam logic [2:0] MODE_SEPIA     = 3'd4;

	localparam logic [1:0] CFG_MODE           = 2'd0;
	localparam logic [1:0] CFG_INPUT_MAX      = 2'd1;
	localparam logic [1:0] CFG_GRAY_MAX       = 2'd2;
	localparam logic [1:0] CFG_CHANNEL_SELECT = 2'd3;

	localparam logic [1:0] CH_RED   = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_BLUE  = 2'd2;

	typedef enum logic [2:0] {
		OP_NONE    = 3'd0,
		OP_BITMAP  = 3'd1,
		OP_GRAY    = 3'd2,
		OP_ISOLATE = 3'd3,
		OP_REMOVE  = 3'd4,
		OP_SEPIA   = 3'd5
	} op_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic [15:0] input_max;
		logic [15:0] gray_max;
		logic [1:0]  channel_select;
	} cfg_t;

	typedef struct packed {
		logic [15:0]         red;
		logic [15:0]         green;
		logic [15:0]         blue;
		logic [SUM_BITS-1:0] sum;
		logic                first_pixel;
		op_t                 op;
	} job_t;

	typedef struct packed {
		logic [OUT_BITS-1:0] out_red;
		logic [OUT_BITS-1:0] out_green;
		logic [OUT_BITS-1:0] out_blue;
		logic                bit_value;
		logic [15:0]         gray_value;
		logic [OUT_BITS-1:0] image_max;
	} result_t;

	// sepia matrix in thousandths, row = output channel, term = input channel
	function automatic logic [9:0] sepia_coef(input logic [1:0] ch, input logic [1:0] term);
		logic [9:0] k;
		case ({ch, term})
			{CH_RED, CH_RED}:     k = 10'd393;
			{CH_RED, CH_GREEN}:   k = 10'd769;
			{CH_RED, CH_BLUE}:    k = 10'd189;
			{CH_GREEN, CH_RED}:   k = 10'd349;
			{CH_GREEN, CH_GREEN}: k = 10'd686;
			{CH_GREEN, CH_BLUE}:  k = 10'd168;
			{CH_BLUE, CH_RED}:    k = 10'd272;
			{CH_BLUE, CH_GREEN}:  k = 10'd534;
			{CH_BLUE, CH_BLUE}:   k = 10'd131;
			default:              k = 10'd0;
		endcase
		return k;
	endfunction

endpackage

### sv/rppt_front.sv
// front stage: takes pixels, masks samples, forms the channel sum and classifies the mode
`timescale 1ns / 1ps
module rppt_front import rppt_pkg::*; #(
	parameter int unsigned SAMPLE_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        pix_valid,
	output logic        pix_stall,
	input  logic [15:0] red,
	input  logic [15:0] green,
	input  logic [15:0] blue,
	input  logic        first_pixel,
	output logic        push,
	output job_t        push_job,
	input  logic        queue_full
);

	localparam logic [15:0] SAMPLE_MASK = 16'((17'd1 << SAMPLE_BITS) - 17'd1);

	logic        valid_s1;
	job_t        job_s1;
	logic        accept;
	logic [15:0] r_m, g_m, b_m;
	op_t         op;

	assign r_m = red & SAMPLE_MASK;
	assign g_m = green & SAMPLE_MASK;
	assign b_m = blue & SAMPLE_MASK;

	always_comb begin
		case (cfg.mode)
			MODE_BITMAP:    op = OP_BITMAP;
			MODE_GRAYSCALE: op = OP_GRAY;
			MODE_ISOLATE:   op = OP_ISOLATE;
			MODE_REMOVE:    op = OP_REMOVE;
			MODE_SEPIA:     op = OP_SEPIA;
			default:        op = OP_NONE;
		endcase
	end

	assign push      = valid_s1 && !queue_full;
	assign pix_stall = valid_s1 && queue_full;
	assign accept    = pix_valid && !pix_stall;
	assign push_job  = job_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			job_s1.red         <= r_m;
			job_s1.green       <= g_m;
			job_s1.blue        <= b_m;
			job_s1.sum         <= SUM_BITS'(r_m) + SUM_BITS'(g_m) + SUM_BITS'(b_m);
			job_s1.first_pixel <= first_pixel;
			job_s1.op          <= op;
		end
	end

endmodule

### sv/rppt_queue.sv
// two-entry job queue between front and back
`timescale 1ns / 1ps
module rppt_queue import rppt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output job_t pop_job,
	output logic empty
);

	job_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign pop_job = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

### sv/rppt_back.sv
// back engine: sequencer for sepia, grayscale divide and the simple modes, with output register
`timescale 1ns / 1ps
module rppt_back import rppt_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    queue_empty,
	input  job_t    pop_job,
	output logic    pop,
	output logic    res_valid,
	input  logic    res_stall,
	output result_t res
);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_DOT   = 7'b0000010,
		ST_RECIP = 7'b0000100,
		ST_FIX   = 7'b0001000,
		ST_GMUL  = 7'b0010000,
		ST_GDIV  = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	localparam logic [5:0] DIV_STEPS = 6'(QUOT_BITS);

	state_t               state_q;
	job_t                 job_q;
	logic [1:0]           ch_q;
	logic [1:0]           term_q;
	logic [DOT_BITS-1:0]  acc_q;
	logic [PROD_BITS-1:0] prod_q;
	logic [OUT_BITS-1:0]  sep_r_q, sep_g_q, sep_b_q;
	logic [OUT_BITS-1:0]  run_max_q;
	logic [QUOT_BITS-1:0] num_q;
	logic [17:0]          den_q;
	logic [17:0]          rem_q;
	logic [5:0]           cnt_q;
	logic                 res_valid_q;
	result_t              res_q;

	logic [15:0]          term_px;
	logic [25:0]          term_prod;
	logic [17:0]          q_est;
	logic [24:0]          q_rem;
	logic [OUT_BITS-1:0]  q_fix;
	logic [18:0]          rem_shift;
	logic                 rem_ge;
	logic [15:0]          imax_nz;
	logic                 load;
	result_t              res_next;
	logic [15:0]          gray_sat;

	assign pop = (state_q == ST_IDLE) && !queue_empty;
	assign load = (state_q == ST_DONE) && (!res_valid_q || !res_stall);

	always_comb begin
		case (term_q)
			CH_RED:   term_px = job_q.red;
			CH_GREEN: term_px = job_q.green;
			default:  term_px = job_q.blue;
		endcase
	end
	assign term_prod = sepia_coef(ch_q, term_q) * term_px;

	// reciprocal estimate is at most one low
	assign q_est = prod_q[RECIP_SHIFT +: 18];
	assign q_rem = {1'b0, acc_q[DOT_BITS-1:3]} - (25'(q_est) * 25'(RECIP_DIV));
	assign q_fix = (q_rem >= 25'(RECIP_DIV)) ? OUT_BITS'(q_est + 18'd1) : OUT_BITS'(q_est);

	assign rem_shift = {rem_q, num_q[QUOT_BITS-1]};
	assign rem_ge    = rem_shift >= {1'b0, den_q};
	assign imax_nz   = (cfg.input_max == 16'd0) ? 16'd1 : cfg.input_max;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			run_max_q <= '0;
			ch_q      <= CH_RED;
			term_q    <= CH_RED;
			cnt_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (!queue_empty) begin
						if (pop_job.first_pixel) begin
							run_max_q <= '0;
						end
						ch_q   <= CH_RED;
						term_q <= CH_RED;
						case (pop_job.op)
							OP_SEPIA: state_q <= ST_DOT;
							OP_GRAY:  state_q <= ST_GMUL;
							default:  state_q <= ST_DONE;
						endcase
					end
				end
				ST_DOT: begin
					if (term_q == CH_BLUE) begin
						term_q  <= CH_RED;
						state_q <= ST_RECIP;
					end else begin
						term_q <= term_q + 2'd1;
					end
				end
				ST_RECIP: begin
					state_q <= ST_FIX;
				end
				ST_FIX: begin
					if (q_fix > run_max_q) begin
						run_max_q <= q_fix;
					end
					if (ch_q == CH_BLUE) begin
						state_q <= ST_DONE;
					end else begin
						ch_q    <= ch_q + 2'd1;
						state_q <= ST_DOT;
					end
				end
				ST_GMUL: begin
					cnt_q   <= DIV_STEPS;
					state_q <= ST_GDIV;
				end
				ST_GDIV: begin
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd1) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= pop_job;
			acc_q <= '0;
		end
		case (state_q)
			ST_DOT: begin
				acc_q <= acc_q + DOT_BITS'(term_prod);
			end
			ST_RECIP: begin
				prod_q <= acc_q[DOT_BITS-1:3] * RECIP_MULT;
			end
			ST_FIX: begin
				acc_q <= '0;
				case (ch_q)
					CH_RED:   sep_r_q <= q_fix;
					CH_GREEN: sep_g_q <= q_fix;
					default:  sep_b_q <= q_fix;
				endcase
			end
			ST_GMUL: begin
				num_q <= job_q.sum * cfg.gray_max;
				den_q <= 18'(imax_nz) * 18'd3;
				rem_q <= '0;
			end
			ST_GDIV: begin
				rem_q <= rem_ge ? 18'(rem_shift - {1'b0, den_q}) : rem_shift[17:0];
				num_q <= {num_q[QUOT_BITS-2:0], rem_ge};
			end
			default: begin
			end
		endcase
	end

	assign gray_sat = (num_q > QUOT_BITS'(cfg.gray_max)) ? cfg.gray_max : num_q[15:0];

	always_comb begin
		res_next = '0;
		case (job_q.op)
			OP_BITMAP: begin
				res_next.bit_value = {job_q.sum, 1'b0} < (19'(cfg.input_max) * 19'd3);
			end
			OP_GRAY: begin
				res_next.gray_value = gray_sat;
			end
			OP_ISOLATE: begin
				res_next.out_red   = (cfg.channel_select == CH_RED)   ? OUT_BITS'(job_q.red)   : '0;
				res_next.out_green = (cfg.channel_select == CH_GREEN) ? OUT_BITS'(job_q.green) : '0;
				res_next.out_blue  = (cfg.channel_select == CH_BLUE)  ? OUT_BITS'(job_q.blue)  : '0;
			end
			OP_REMOVE: begin
				res_next.out_red   = (cfg.channel_select == CH_RED)   ? '0 : OUT_BITS'(job_q.red);
				res_next.out_green = (cfg.channel_select == CH_GREEN) ? '0 : OUT_BITS'(job_q.green);
				res_next.out_blue  = (cfg.channel_select == CH_BLUE)  ? '0 : OUT_BITS'(job_q.blue);
			end
			OP_SEPIA: begin
				res_next.out_red   = sep_r_q;
				res_next.out_green = sep_g_q;
				res_next.out_blue  = sep_b_q;
				res_next.image_max = run_max_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_next;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

### sv/rgb_pixel_point_transform_core.sv
// top level of the rgb pixel point transform: config registers, front, queue and back
//
//  channel   handshake              beat carries
//  pix       pix_valid / pix_stall  red, green, blue, first_pixel
//  res       res_valid / res_stall  out_red, out_green, out_blue, bit_value, gray_value, image_max
//  cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  back engine per pixel: bitmap, isolate, remove and unused modes go straight to the result,
//  sepia runs three rows of three mac steps, each row with a reciprocal multiply and fixup,
//  grayscale a multiply then a 34-step restoring divider
//  front register and a two-entry queue let pixels enter while the back is busy
//  arst_n clears all control state and loads the register reset values
//  the result register holds under res_stall while the back prepares the next pixel
`timescale 1ns / 1ps
module rgb_pixel_point_transform_core import rppt_pkg::*; #(
	parameter int unsigned SAMPLE_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        pix_valid,
	output logic        pix_stall,
	input  logic [15:0] red,
	input  logic [15:0] green,
	input  logic [15:0] blue,
	input  logic        first_pixel,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [16:0] out_red,
	output logic [16:0] out_green,
	output logic [16:0] out_blue,
	output logic        bit_value,
	output logic [15:0] gray_value,
	output logic [16:0] image_max
);

	cfg_t    cfg_q;
	logic    push;
	job_t    push_job;
	logic    queue_full;
	logic    pop;
	job_t    pop_job;
	logic    queue_empty;
	result_t res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode           <= MODE_BITMAP;
			cfg_q.input_max      <= 16'd255;
			cfg_q.gray_max       <= 16'd255;
			cfg_q.channel_select <= CH_RED;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MODE:           cfg_q.mode           <= cfg_data[2:0];
				CFG_INPUT_MAX:      cfg_q.input_max      <= cfg_data;
				CFG_GRAY_MAX:       cfg_q.gray_max       <= cfg_data;
				CFG_CHANNEL_SELECT: cfg_q.channel_select <= cfg_data[1:0];
				default: begin
				end
			endcase
		end
	end

	rppt_front #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.pix_valid  (pix_valid),
		.pix_stall  (pix_stall),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.first_pixel(first_pixel),
		.push       (push),
		.push_job   (push_job),
		.queue_full (queue_full)
	);

	rppt_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_job(push_job),
		.full    (queue_full),
		.pop     (pop),
		.pop_job (pop_job),
		.empty   (queue_empty)
	);

	rppt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.queue_empty(queue_empty),
		.pop_job    (pop_job),
		.pop        (pop),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res)
	);

	assign out_red    = res.out_red;
	assign out_green  = res.out_green;
	assign out_blue   = res.out_blue;
	assign bit_value  = res.bit_value;
	assign gray_value = res.gray_value;
	assign image_max  = res.image_max;

endmodule

### tb/rgb_pixel_point_transform_core_test.sv
// self-checking testbench for the rgb pixel point transform core
`timescale 1ns / 1ps
module rgb_pixel_point_transform_core_test;
	import rppt_pkg::*;

	localparam logic [2:0] MODE_SPARE_5 = 3'd5;
	localparam logic [2:0] MODE_SPARE_6 = 3'd6;
	localparam logic [2:0] MODE_SPARE_7 = 3'd7;
	localparam logic [1:0] CH_NONE = 2'd3;
	localparam int RANDOM_ITEMS = 1225;
	localparam int CALM_ITEMS = 150;
	localparam int STALL_LIMIT = 1000;
	localparam result_t ZEROS = '0;

	typedef struct {
		cfg_t        setup;
		logic [15:0] r;
		logic [15:0] g;
		logic [15:0] b;
		logic        first;
		logic        known;
		result_t     want;
	} probe_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        pix_valid;
	logic        pix_stall;
	logic [15:0] red;
	logic [15:0] green;
	logic [15:0] blue;
	logic        first_pixel;
	logic        res_valid;
	logic        res_stall;
	logic [16:0] out_red;
	logic [16:0] out_green;
	logic [16:0] out_blue;
	logic        bit_value;
	logic [15:0] gray_value;
	logic [16:0] image_max;

	cfg_t        cfg;
	logic [16:0] sepia_peak;
	result_t     pending_results[$];
	probe_t      probes[$];
	bit          calm;
	int          gap_odds;
	int          pixels_sent;
	int          results_checked;
	int          mismatches;
	int          phases;

	rgb_pixel_point_transform_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.pix_valid  (pix_valid),
		.pix_stall  (pix_stall),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.first_pixel(first_pixel),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.out_red    (out_red),
		.out_green  (out_green),
		.out_blue   (out_blue),
		.bit_value  (bit_value),
		.gray_value (gray_value),
		.image_max  (image_max)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic result_t transform_pixel(input logic [15:0] r, g, b, input logic first);
		result_t     res;
		logic [17:0] sum;
		logic [63:0] den;
		logic [63:0] quo;
		logic [31:0] tone [3];
		logic [16:0] chan [3];
		logic        pass_chan;
		res = ZEROS;
		pass_chan = 1'b0;
		chan[0] = {1'b0, r};
		chan[1] = {1'b0, g};
		chan[2] = {1'b0, b};
		sum = 18'(r) + 18'(g) + 18'(b);
		if (first)
			sepia_peak = '0;
		case (cfg.mode)
			MODE_BITMAP: res.bit_value = (64'(sum) * 2) < (64'(cfg.input_max) * 3);
			MODE_GRAYSCALE: begin
				// zero full scale divides as if it were one
				den = 64'(cfg.input_max == 16'd0 ? 16'd1 : cfg.input_max) * 3;
				quo = (64'(sum) * 64'(cfg.gray_max)) / den;
				res.gray_value = (quo > 64'(cfg.gray_max)) ? cfg.gray_max : quo[15:0];
			end
			MODE_ISOLATE: begin
				for (int c = 0; c < 3; c++)
					if (c != cfg.channel_select)
						chan[c] = '0;
				pass_chan = 1'b1;
			end
			MODE_REMOVE: begin
				for (int c = 0; c < 3; c++)
					if (c == cfg.channel_select)
						chan[c] = '0;
				pass_chan = 1'b1;
			end
			MODE_SEPIA: begin
				tone[0] = (393 * 32'(r) + 769 * 32'(g) + 189 * 32'(b)) / 1000;
				tone[1] = (349 * 32'(r) + 686 * 32'(g) + 168 * 32'(b)) / 1000;
				tone[2] = (272 * 32'(r) + 534 * 32'(g) + 131 * 32'(b)) / 1000;
				for (int c = 0; c < 3; c++) begin
					chan[c] = tone[c][16:0];
					if (tone[c] > 32'(sepia_peak))
						sepia_peak = tone[c][16:0];
				end
				res.image_max = sepia_peak;
				pass_chan = 1'b1;
			end
			default: ;
		endcase
		if (pass_chan) begin
			res.out_red = chan[0];
			res.out_green = chan[1];
			res.out_blue = chan[2];
		end
		return res;
	endfunction

	task automatic add_probe(input cfg_t setup, input logic [15:0] r, g, b, input logic first,
			input logic known, input result_t want);
		probe_t p;
		p.setup = setup;
		p.r = r;
		p.g = g;
		p.b = b;
		p.first = first;
		p.known = known;
		p.want = want;
		probes.push_back(p);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
		cfg_index = idx;
		cfg_data = data;
		cfg_valid = 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CFG_MODE:           cfg.mode = data[2:0];
			CFG_INPUT_MAX:      cfg.input_max = data;
			CFG_GRAY_MAX:       cfg.gray_max = data;
			CFG_CHANNEL_SELECT: cfg.channel_select = data[1:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic settle();
		pix_valid = 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		phases++;
	endtask

	task automatic send_pixel(input logic [15:0] r, g, b, input logic first,
			input logic known, input result_t want);
		result_t predicted;
		if (!calm && gap_odds != 0 && $urandom_range(1, 8) <= gap_odds) begin
			pix_valid = 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		red = r;
		green = g;
		blue = b;
		first_pixel = first;
		pix_valid = 1'b1;
		@(posedge clk);
		while (pix_stall)
			@(posedge clk);
		predicted = transform_pixel(r, g, b, first);
		pending_results.push_back(known ? want : predicted);
		pixels_sent++;
		@(negedge clk);
	endtask

	task automatic compare(input string name, input logic [16:0] want, input logic [16:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result beat with nothing pending", $time);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				compare("out_red", want.out_red, out_red);
				compare("out_green", want.out_green, out_green);
				compare("out_blue", want.out_blue, out_blue);
				compare("bit_value", 17'(want.bit_value), 17'(bit_value));
				compare("gray_value", 17'(want.gray_value), 17'(gray_value));
				compare("image_max", want.image_max, image_max);
			end
			results_checked++;
		end
	end

	// result side back-pressure in bursts, none near the end
	initial begin
		res_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				res_stall = 1'b1;
				repeat ($urandom_range(1, 17)) @(negedge clk);
				res_stall = 1'b0;
				repeat ($urandom_range(1, 40)) @(negedge clk);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((pix_valid && !pix_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog: no beat in %0d cycles", STALL_LIMIT);
		$display("rgb_pixel_point_transform_core: mismatch");
		$finish;
	end

	initial begin
		probe_t      p;
		int          random_sent;
		int          phase_len;
		int          kind;
		logic [2:0]  new_mode;
		logic [15:0] new_in_max;
		logic [15:0] new_gray_max;
		logic [1:0]  new_ch;
		logic [15:0] pr;
		logic [15:0] pg;
		logic [15:0] pb;
		logic        pf;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_MODE;
		cfg_data = '0;
		pix_valid = 1'b0;
		red = '0;
		green = '0;
		blue = '0;
		first_pixel = 1'b0;
		calm = 1'b0;
		gap_odds = 2;
		pixels_sent = 0;
		results_checked = 0;
		mismatches = 0;
		phases = 0;
		random_sent = 0;
		cfg = '{MODE_BITMAP, 16'd255, 16'd255, CH_RED};
		sepia_peak = '0;

		// bitmap at reset values, threshold edges, zero full scale
		add_probe('{MODE_BITMAP, 16'd255, 16'd255, CH_RED}, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1,
			'{17'd0, 17'd0, 17'd0, 1'b1, 16'd0, 17'd0});
		add_probe('{MODE_BITMAP, 16'd255, 16'd255, CH_RED}, 16'd255, 16'd255, 16'd255, 1'b0,
			1'b1, ZEROS);
		add_probe('{MODE_BITMAP, 16'd255, 16'd255, CH_RED}, 16'd127, 16'd127, 16'd128, 1'b0,
			1'b1, '{17'd0, 17'd0, 17'd0, 1'b1, 16'd0, 17'd0});
		add_probe('{MODE_BITMAP, 16'd255, 16'd255, CH_RED}, 16'd127, 16'd128, 16'd128, 1'b0,
			1'b1, ZEROS);
		add_probe('{MODE_BITMAP, 16'd0, 16'd255, CH_RED}, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1, ZEROS);
		// grayscale extremes and saturation
		add_probe('{MODE_GRAYSCALE, 16'd255, 16'd255, CH_RED}, 16'd255, 16'd255, 16'd255, 1'b0,
			1'b1, '{17'd0, 17'd0, 17'd0, 1'b0, 16'd255, 17'd0});
		add_probe('{MODE_GRAYSCALE, 16'd0, 16'd65535, CH_RED}, 16'd1, 16'd1, 16'd1, 1'b0, 1'b1,
			'{17'd0, 17'd0, 17'd0, 1'b0, 16'd65535, 17'd0});
		add_probe('{MODE_GRAYSCALE, 16'd100, 16'd1000, CH_RED}, 16'hffff, 16'hffff, 16'hffff,
			1'b0, 1'b1, '{17'd0, 17'd0, 17'd0, 1'b0, 16'd1000, 17'd0});
		add_probe('{MODE_GRAYSCALE, 16'd65535, 16'd65535, CH_RED}, 16'hffff, 16'hffff, 16'hffff,
			1'b0, 1'b1, '{17'd0, 17'd0, 17'd0, 1'b0, 16'd65535, 17'd0});
		add_probe('{MODE_GRAYSCALE, 16'd1000, 16'd777, CH_RED}, 16'd123, 16'd456, 16'd789, 1'b0,
			1'b0, ZEROS);
		// isolate and remove, including the unused channel code
		add_probe('{MODE_ISOLATE, 16'd255, 16'd255, CH_RED}, 16'd1, 16'd2, 16'd3, 1'b0, 1'b1,
			'{17'd1, 17'd0, 17'd0, 1'b0, 16'd0, 17'd0});
		add_probe('{MODE_ISOLATE, 16'd255, 16'd255, CH_BLUE}, 16'hffff, 16'hffff, 16'hffff,
			1'b0, 1'b1, '{17'd0, 17'd0, 17'd65535, 1'b0, 16'd0, 17'd0});
		add_probe('{MODE_ISOLATE, 16'd255, 16'd255, CH_NONE}, 16'hffff, 16'hffff, 16'hffff,
			1'b0, 1'b1, ZEROS);
		add_probe('{MODE_REMOVE, 16'd255, 16'd255, CH_GREEN}, 16'd10, 16'd20, 16'd30, 1'b0, 1'b1,
			'{17'd10, 17'd0, 17'd30, 1'b0, 16'd0, 17'd0});
		add_probe('{MODE_REMOVE, 16'd255, 16'd255, CH_NONE}, 16'hffff, 16'd0, 16'hffff, 1'b0,
			1'b1, '{17'd65535, 17'd0, 17'd65535, 1'b0, 16'd0, 17'd0});
		// sepia peak tracking across image marks and other modes
		add_probe('{MODE_SEPIA, 16'd255, 16'd255, CH_RED}, 16'hffff, 16'hffff, 16'hffff, 1'b1,
			1'b1, '{17'd88537, 17'd78838, 17'd61406, 1'b0, 16'd0, 17'd88537});
		add_probe('{MODE_SEPIA, 16'd255, 16'd255, CH_RED}, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1,
			'{17'd0, 17'd0, 17'd0, 1'b0, 16'd0, 17'd88537});
		add_probe('{MODE_SEPIA, 16'd255, 16'd255, CH_RED}, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1, ZEROS);
		add_probe('{MODE_SEPIA, 16'd255, 16'd255, CH_RED}, 16'd100, 16'd200, 16'd50, 1'b0, 1'b0,
			ZEROS);
		add_probe('{MODE_SPARE_5, 16'd255, 16'd255, CH_RED}, 16'hffff, 16'hffff, 16'hffff, 1'b1,
			1'b1, ZEROS);
		add_probe('{MODE_SEPIA, 16'd255, 16'd255, CH_RED}, 16'hffff, 16'hffff, 16'hffff, 1'b0,
			1'b1, '{17'd88537, 17'd78838, 17'd61406, 1'b0, 16'd0, 17'd88537});
		add_probe('{MODE_SPARE_6, 16'd255, 16'd255, CH_RED}, 16'hffff, 16'hffff, 16'hffff, 1'b0,
			1'b1, ZEROS);
		add_probe('{MODE_BITMAP, 16'd255, 16'd255, CH_RED}, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1,
			'{17'd0, 17'd0, 17'd0, 1'b1, 16'd0, 17'd0});
		add_probe('{MODE_SPARE_7, 16'd255, 16'd255, CH_RED}, 16'd1, 16'd2, 16'd3, 1'b0, 1'b1,
			ZEROS);
		add_probe('{MODE_SEPIA, 16'd255, 16'd255, CH_RED}, 16'd1, 16'd1, 16'd1, 1'b0, 1'b1,
			'{17'd1, 17'd1, 17'd0, 1'b0, 16'd0, 17'd1});

		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (probes[n]) begin
			p = probes[n];
			if (p.setup != cfg) begin
				settle();
				if (p.setup.mode != cfg.mode)
					write_reg(CFG_MODE, {13'd0, p.setup.mode});
				if (p.setup.input_max != cfg.input_max)
					write_reg(CFG_INPUT_MAX, p.setup.input_max);
				if (p.setup.gray_max != cfg.gray_max)
					write_reg(CFG_GRAY_MAX, p.setup.gray_max);
				if (p.setup.channel_select != cfg.channel_select)
					write_reg(CFG_CHANNEL_SELECT, {14'd0, p.setup.channel_select});
				cfg_valid = 1'b0;
			end
			send_pixel(p.r, p.g, p.b, p.first, p.known, p.want);
		end

		while (random_sent < RANDOM_ITEMS) begin
			settle();
			gap_odds = $urandom_range(0, 3);
			case ($urandom_range(0, 15))
				0, 1, 2:    new_mode = MODE_BITMAP;
				3, 4, 5:    new_mode = MODE_GRAYSCALE;
				6, 7:       new_mode = MODE_ISOLATE;
				8, 9:       new_mode = MODE_REMOVE;
				10, 11, 12: new_mode = MODE_SEPIA;
				13:         new_mode = MODE_SPARE_5;
				14:         new_mode = MODE_SPARE_6;
				default:    new_mode = MODE_SPARE_7;
			endcase
			case ($urandom_range(0, 9))
				0:       new_in_max = 16'd0;
				1:       new_in_max = 16'd1;
				2:       new_in_max = 16'hffff;
				3:       new_in_max = 16'd255;
				default: new_in_max = 16'($urandom_range(1, 65535));
			endcase
			case ($urandom_range(0, 9))
				0:       new_gray_max = 16'd0;
				1:       new_gray_max = 16'd1;
				2:       new_gray_max = 16'hffff;
				default: new_gray_max = 16'($urandom_range(1, 65535));
			endcase
			case ($urandom_range(0, 3))
				0:       new_ch = CH_RED;
				1:       new_ch = CH_GREEN;
				2:       new_ch = CH_BLUE;
				default: new_ch = CH_NONE;
			endcase
			// upper data bits are don't-care for the narrow registers
			write_reg(CFG_MODE, {13'($urandom_range(0, 8191)), new_mode});
			write_reg(CFG_INPUT_MAX, new_in_max);
			write_reg(CFG_GRAY_MAX, new_gray_max);
			write_reg(CFG_CHANNEL_SELECT, {14'($urandom_range(0, 16383)), new_ch});
			cfg_valid = 1'b0;
			phase_len = $urandom_range(20, 80);
			for (int i = 0; i < phase_len && random_sent < RANDOM_ITEMS; i++) begin
				kind = $urandom_range(0, 15);
				if (kind <= 10) begin
					pr = 16'($urandom_range(0, cfg.input_max));
					pg = 16'($urandom_range(0, cfg.input_max));
					pb = 16'($urandom_range(0, cfg.input_max));
				end else if (kind <= 12) begin
					pr = 16'($urandom_range(0, 65535));
					pg = 16'($urandom_range(0, 65535));
					pb = 16'($urandom_range(0, 65535));
				end else if (kind == 13) begin
					pr = cfg.input_max;
					pg = cfg.input_max;
					pb = cfg.input_max;
				end else if (kind == 14) begin
					pr = 16'd0;
					pg = 16'd0;
					pb = 16'd0;
				end else begin
					pr = 16'hffff;
					pg = 16'hffff;
					pb = 16'hffff;
				end
				pf = (i == 0 && cfg.mode == MODE_SEPIA) || ($urandom_range(0, 15) == 0);
				send_pixel(pr, pg, pb, pf, 1'b0, ZEROS);
				random_sent++;
				if (random_sent >= RANDOM_ITEMS - CALM_ITEMS)
					calm = 1'b1;
			end
		end

		pix_valid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (48) @(posedge clk);
		$display("pixels driven: %0d (%0d directed), result beats checked: %0d",
			pixels_sent, probes.size(), results_checked);
		$display("register settings exercised: %0d, spanning every mode code and range extreme",
			phases);
		if (mismatches == 0)
			$display("rgb_pixel_point_transform_core: match");
		else
			$display("rgb_pixel_point_transform_core: mismatch");
		$finish;
	end

endmodule

### rgb_pixel_point_transform_core.f
sv/rppt_pkg.sv
sv/rppt_front.sv
sv/rppt_queue.sv
sv/rppt_back.sv
sv/rgb_pixel_point_transform_core.sv
tb/rgb_pixel_point_transform_core_test.sv
